// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low, generic message
`define SHFD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shfd assertion failed");

// clocked assertion, disabled while reset is low, caller message
`define SHFD_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// File: sv/shfd_pkg.sv
// types and constants of the sync header frame deframer
// used by every module of the block, no dependencies
`default_nettype none

package shfd_pkg;

    localparam int unsigned SHORT_FRAME_BYTES = 12;
    localparam int unsigned LONG_FRAME_BYTES  = 20;
    localparam int unsigned STORE_DEPTH       =
        (SHORT_FRAME_BYTES > LONG_FRAME_BYTES) ? SHORT_FRAME_BYTES : LONG_FRAME_BYTES;
    localparam int unsigned POS_W             = $clog2(STORE_DEPTH);

    localparam logic [7:0] HDR_FIRST = 8'hAA;
    localparam logic [7:0] HDR_SHORT = 8'h55;
    localparam logic [7:0] HDR_LONG  = 8'h5A;

    localparam logic FMT_SHORT = 1'b0;
    localparam logic FMT_LONG  = 1'b1;

    localparam int unsigned RESULT_W = 136;

    // first member in the top bits, so sequence_number sits in the low bits
    typedef struct packed {
        logic [7:0]         mode_code;
        logic [15:0]        frame_rate_tenths;
        logic [15:0]        det_score;
        logic [15:0]        target_x_pixel;
        logic [15:0]        ball_x_pixel;
        logic signed [15:0] velocity;
        logic [15:0]        target_pos;
        logic [15:0]        ball_pos;
        logic [7:0]         flag_bits;
        logic [7:0]         sequence_number;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic             hunting;
        logic [POS_W-1:0] pos;
    } t_parser_status;

endpackage

`default_nettype wire

// File: sv/shfd_in_stage.sv
// input register of the deframer, holds one received byte
// depends on shfd_pkg
`default_nettype none

module shfd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data,
    input  wire logic              i_take,
    output shfd_pkg::t_in_item     o_item
);
    import shfd_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       n_valid;

    always_comb begin
        o_ready = !r_valid || i_take;
        n_valid = r_valid && !i_take;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_item = '{valid: r_valid, data: r_data};

endmodule

`default_nettype wire

// File: sv/shfd_parser.sv
// header hunt, frame store, running checksum and field decode
// depends on shfd_pkg
`default_nettype none

module shfd_parser (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_frame_format,
    input  wire logic                    i_take,
    input  wire logic [7:0]              i_byte,
    output logic                         o_res_valid,
    output shfd_pkg::t_result            o_res,
    output shfd_pkg::t_parser_status     o_status
);
    import shfd_pkg::*;

    logic [7:0]       r_store [STORE_DEPTH];
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_sum;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       n_sum;
    logic             w_wr_en;
    logic [POS_W-1:0] w_wr_idx;
    logic             w_lng;
    logic [POS_W:0]   w_size;
    logic [POS_W:0]   w_pos_inc;
    logic [7:0]       w_second;

    always_comb begin
        w_lng       = (i_frame_format == FMT_LONG);
        w_size      = w_lng ? (POS_W+1)'(LONG_FRAME_BYTES) : (POS_W+1)'(SHORT_FRAME_BYTES);
        w_second    = w_lng ? HDR_LONG : HDR_SHORT;
        w_pos_inc   = {1'b0, r_pos} + (POS_W+1)'(1);
        n_pos       = r_pos;
        n_sum       = r_sum;
        w_wr_en     = 1'b0;
        w_wr_idx    = r_pos;
        o_res_valid = 1'b0;
        if (i_take) begin
            priority if (r_pos == POS_W'(0)) begin
                if (i_byte == HDR_FIRST) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = POS_W'(0);
                    n_sum    = i_byte;
                    n_pos    = POS_W'(1);
                end
            end else if (r_pos == POS_W'(1)) begin
                priority if (i_byte == w_second) begin
                    w_wr_en = 1'b1;
                    n_sum   = r_sum + i_byte;
                    n_pos   = POS_W'(2);
                end else if (i_byte == HDR_FIRST) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = POS_W'(0);
                    n_sum    = i_byte;
                    n_pos    = POS_W'(1);
                end else begin
                    n_sum = 8'h00;
                    n_pos = POS_W'(0);
                end
            end else begin
                w_wr_en = ({1'b0, r_pos} < (POS_W+1)'(STORE_DEPTH));
                if (w_pos_inc < w_size) begin
                    n_sum = r_sum + i_byte;
                    n_pos = w_pos_inc[POS_W-1:0];
                end else begin
                    o_res_valid = (r_sum == i_byte);
                    n_sum       = 8'h00;
                    n_pos       = POS_W'(0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
        if (w_wr_en) begin
            r_store[w_wr_idx] <= i_byte;
        end
    end

    always_comb begin
        o_res                 = '0;
        o_res.sequence_number = r_store[2];
        o_res.flag_bits       = r_store[3];
        o_res.ball_pos        = {r_store[5], r_store[4]};
        o_res.target_pos      = {r_store[7], r_store[6]};
        if (w_lng) begin
            o_res.velocity          = {r_store[9], r_store[8]};
            o_res.ball_x_pixel      = {r_store[11], r_store[10]};
            o_res.target_x_pixel    = {r_store[13], r_store[12]};
            o_res.det_score         = {r_store[15], r_store[14]};
            o_res.frame_rate_tenths = {r_store[17], r_store[16]};
            o_res.mode_code         = r_store[18];
        end else begin
            o_res.det_score = {r_store[9], r_store[8]};
            o_res.mode_code = r_store[10];
        end
    end

    assign o_status = '{hunting: (r_pos == POS_W'(0)), pos: r_pos};

endmodule

`default_nettype wire

// File: sv/sync_header_frame_deframer_unit.sv
// sync header frame deframer: receives bytes, emits decoded frames
// channels:
//   s_axis carries one received byte per item (tdata bits 7:0)
//   m_axis carries one decoded frame per item, 136 bits of fields
//   i_cfg_we/i_cfg_data write frame_format (0 short 0x55, 1 long 0x5A)
// a frame is 0xAA, the format header byte, payload, then an 8-bit sum
// of all earlier bytes; only frames whose sum matches give an item
// m_axis_tvalid rises once the last byte of a good frame has passed the
// input register and then the result register
// throughput: one byte per cycle while no result is held back by m_axis,
// set by the combinational parse step between the input and result registers
// reset: hunt restarts, no result pending, format short
// when m_axis stalls with a result held, the input register can still fill
// with one byte; s_axis_tready is low while it is full, until the result is taken
// depends on shfd_pkg, shfd_in_stage, shfd_parser, assert_macros.svh
`default_nettype none

module sync_header_frame_deframer_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // rx_byte
    input  wire logic [7:0]                     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // sequence_number, flag_bits, ball_pos, target_pos, velocity,
    // ball_x_pixel, target_x_pixel, det_score, frame_rate_tenths, mode_code
    output logic [shfd_pkg::RESULT_W-1:0]       m_axis_tdata
);
    import shfd_pkg::*;

    `include "assert_macros.svh"

    logic           r_frame_format;
    logic           r_out_valid;
    t_result        r_out;
    t_in_item       w_item;
    logic           w_take;
    logic           w_res_valid;
    t_result        w_res;
    t_parser_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_format <= FMT_SHORT;
        end else if (i_cfg_we) begin
            r_frame_format <= i_cfg_data;
        end
    end

    assign w_take = w_item.valid && (!r_out_valid || m_axis_tready);

    shfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    shfd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_format (r_frame_format),
        .i_take         (w_take),
        .i_byte         (w_item.data),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .o_status       (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `SHFD_ASSERT(a_res_from_take, i_clk, i_rst_n, (w_res_valid |-> w_take))
    `SHFD_ASSERT(a_res_not_lost, i_clk, i_rst_n, (w_res_valid |=> r_out_valid))
    `SHFD_ASSERT_MSG(a_no_overwrite, i_clk, i_rst_n,
        ((r_out_valid && !m_axis_tready) |-> !w_take), "parse while result blocked")
    `SHFD_ASSERT_MSG(a_pos_range, i_clk, i_rst_n,
        (({1'b0, w_status.pos} < (POS_W+1)'(STORE_DEPTH))
            && (w_status.hunting == (w_status.pos == POS_W'(0)))),
        "frame position out of range")

endmodule

`default_nettype wire
